/* hdl/u2bd_pkg.sv */
package u2bd_pkg;

  localparam int VALUE_W  = 64;
  localparam int BASE_MIN = 2;
  localparam int BASE_MAX = 36;
  localparam int BASE_HEX = 16;
  localparam int PREC_NONE = -1;

  typedef struct packed {
    logic [63:0]       value;
    logic [5:0]        base;
    logic signed [7:0] precision;
    logic [6:0]        width;
    logic              zero_pad;
    logic              left_align;
    logic              alt_form;
    logic              upper_case;
    logic              sign_reserved;
    logic [1:0]        prefix_reserved;
    logic              space_reserved;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       char_valid;
    logic       last;
  } out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [63:0]       value;
    logic [5:0]        base;
    logic              upper;
    logic              empty_run;
    logic signed [7:0] prec;
    logic              wpad;
    logic [6:0]        wid;
    logic signed [8:0] room;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_CALC,
    B_EMIT,
    B_BLANK
  } back_state_t;

  // ASCII code of one digit
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = 8'h30 + {2'b00, d};
    end else if (upper) begin
      c = 8'h41 + {2'b00, d} - 8'd10;
    end else begin
      c = 8'h61 + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* hdl/u2bd_fifo.sv */
module u2bd_fifo import u2bd_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

/* hdl/u2bd_ram.sv */
module u2bd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/u2bd_front.sv */
module u2bd_front import u2bd_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  output logic full,
  input  logic cmd_pop,
  output cmd_t cmd,
  output logic cmd_empty
);
  localparam logic [63:0] MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  cmd_t            cls;
  logic [63:0]     v;
  logic [$bits(cmd_t)-1:0] cmd_bits;
  logic [1:0]      unused_count;

  // classify the beat
  always_comb begin
    v             = item.value & MASK;
    cls.value     = v;
    cls.upper     = item.upper_case;
    cls.prec      = item.precision;
    cls.wid       = item.width;
    cls.empty_run = (v == '0) && (item.precision == 8'sd0) &&
                    ((item.base == 6'(BASE_HEX)) || !item.alt_form);
    if (item.base < 6'(BASE_MIN)) begin
      cls.base = 6'(BASE_MIN);
    end else if (item.base > 6'(BASE_MAX)) begin
      cls.base = 6'(BASE_MAX);
    end else begin
      cls.base = item.base;
    end
    cls.wpad = (item.precision == 8'(PREC_NONE)) && item.zero_pad && !item.left_align;
    cls.room = $signed({2'b00, item.width}) - $signed({8'd0, item.sign_reserved})
             - $signed({7'd0, item.prefix_reserved}) - $signed({8'd0, item.space_reserved});
  end

  // job queue toward the back end
  u2bd_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty),
    .count (unused_count)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

/* hdl/u2bd_back.sv */
module u2bd_back import u2bd_pkg::*; #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64,
  parameter int OQ_DEPTH   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  logic [$clog2(OQ_DEPTH+1)-1:0] oq_count,
  output logic                          oq_push,
  output out_t                          oq_data
);
  localparam int NCH = (VALUE_BITS + 7) / 8;
  localparam int QW  = NCH * 8;
  localparam int CCW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int LW  = $clog2(VALUE_BITS + 1);
  localparam int CW  = $clog2(MAX_CHARS + 1);
  localparam int AW  = $clog2(MAX_CHARS);

  back_state_t      state, state_next;
  logic [5:0]       base;
  logic             upper;
  logic signed [7:0] prec;
  logic             wpad;
  logic [6:0]       wid;
  logic signed [8:0] room;
  logic [QW-1:0]    quot;
  logic [5:0]       rem;
  logic [CCW-1:0]   ccnt;
  logic [LW-1:0]    len;
  logic [CW-1:0]    p;
  logic             pend_v, pend_ram, pend_last, pend_blank, pend_upper;

  logic             load, div_step, chunk_end, calc, issue, space;
  logic [QW+7:0]    qwide;
  logic [QW-1:0]    qnext;
  logic [5:0]       rnext;
  logic [7:0]       qbits;
  logic [6:0]       trial;
  logic [CW-1:0]    tot_m1;
  int               tot;
  logic [5:0]       rd_digit;

  // one chunk of restoring division, eight quotient bits
  always_comb begin
    rnext = rem;
    qbits = '0;
    trial = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {rnext, quot[QW-8+i]};
      if (trial >= {1'b0, base}) begin
        rnext    = 6'(trial - {1'b0, base});
        qbits[i] = 1'b1;
      end else begin
        rnext = trial[5:0];
      end
    end
    qwide = {quot, qbits};
    qnext = qwide[QW-1:0];
  end

  assign chunk_end = (ccnt == CCW'(NCH - 1));
  assign space     = (32'(oq_count) + 32'(pend_v)) < OQ_DEPTH;

  // padded length from digit count
  always_comb begin
    tot = int'(len);
    if (int'(len) <= int'(prec)) begin
      tot = int'(prec);
    end else if (int'(len) <= int'(wid) && wpad) begin
      if (int'(room) > int'(len)) begin
        tot = int'(room);
      end
    end
    if (tot > MAX_CHARS) begin
      tot = MAX_CHARS;
    end
    tot_m1 = CW'(tot - 1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!cmd_empty) state_next = cmd.empty_run ? B_BLANK : B_DIV;
      B_DIV:   if (chunk_end && qnext == '0) state_next = B_CALC;
      B_CALC:  state_next = B_EMIT;
      B_EMIT:  if (space && p == '0) state_next = B_IDLE;
      B_BLANK: if (space) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load     = 1'b0;
    div_step = 1'b0;
    calc     = 1'b0;
    issue    = 1'b0;
    unique case (state)
      B_IDLE:  load = !cmd_empty;
      B_DIV:   div_step = 1'b1;
      B_CALC:  calc = 1'b1;
      B_EMIT:  issue = space;
      B_BLANK: issue = space;
      default: ;
    endcase
  end

  assign cmd_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= issue;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load) begin
      base  <= cmd.base;
      upper <= cmd.upper;
      prec  <= cmd.prec;
      wpad  <= cmd.wpad;
      wid   <= cmd.wid;
      room  <= cmd.room;
      quot  <= QW'(cmd.value);
      rem   <= '0;
      ccnt  <= '0;
      len   <= '0;
    end
    if (div_step) begin
      quot <= qnext;
      if (chunk_end) begin
        rem  <= '0;
        ccnt <= '0;
        len  <= len + 1'b1;
      end else begin
        rem  <= rnext;
        ccnt <= ccnt + 1'b1;
      end
    end
    if (calc) begin
      p <= tot_m1;
    end
    if (issue && state == B_EMIT) begin
      p <= p - 1'b1;
    end
    if (issue) begin
      pend_ram   <= (state == B_EMIT) && (32'(p) < 32'(len));
      pend_last  <= (state == B_BLANK) || (p == '0);
      pend_blank <= (state == B_BLANK);
      pend_upper <= upper;
    end
  end

  // digit store, least significant digit at address zero
  u2bd_ram #(.WIDTH(6), .DEPTH(MAX_CHARS)) u_digits (
    .clk   (clk),
    .we    (div_step && chunk_end && (32'(len) < MAX_CHARS)),
    .waddr (AW'(len)),
    .wdata (rnext),
    .raddr (AW'(p)),
    .rdata (rd_digit)
  );

  // result beat
  always_comb begin
    oq_push = pend_v;
    if (pend_blank) begin
      oq_data.character  = '0;
      oq_data.char_valid = 1'b0;
    end else begin
      oq_data.character  = digit_char(pend_ram ? rd_digit : 6'd0, pend_upper);
      oq_data.char_valid = 1'b1;
    end
    oq_data.last = pend_last;
  end

endmodule

/* hdl/unsigned_to_base_digits_padded_top.sv */
// Digits come from the single divider, which takes 8 quotient bits a cycle;
// NCH = ceil(VALUE_BITS/8) eight-bit chunks make up the division for each digit.
// Characters go out one per cycle while the result queue has room; the back end
// handles one item at a time, and the job queue holds further items meanwhile.
// Reset: synchronous active-high rst empties both queues and idles the back end;
// the digit store needs no clearing.
module unsigned_to_base_digits_padded_top import u2bd_pkg::*; #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);
  localparam int OQ_DEPTH = 4;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  logic oq_push, oq_full;
  out_t oq_data;
  logic [$clog2(OQ_DEPTH+1)-1:0] oq_count;
  logic [$bits(out_t)-1:0] res_bits;

  u2bd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  u2bd_back #(
    .MAX_CHARS  (MAX_CHARS),
    .VALUE_BITS (VALUE_BITS),
    .OQ_DEPTH   (OQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_data   (oq_data)
  );

  // result queue
  u2bd_fifo #(.W($bits(out_t)), .DEPTH(OQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_data),
    .full  (oq_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty),
    .count (oq_count)
  );

  assign result = out_t'(res_bits);

  // checks
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (rst)
    !(oq_push && oq_full)) else $error("result queue overflow");

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty) else $error("job taken from empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty) else $error("results present after reset");

  a_blank_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.char_valid) |-> result.last) else $error("blank beat not last");

endmodule

/* sim/tb.sv */
module tb import u2bd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_t  item;
  logic empty;
  logic pop = 1'b0;
  out_t result;

  unsigned_to_base_digits_padded_top i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  out_t char_q[$];
  int   n_mismatch = 0;
  int   idle_cycles = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   timed_out = 1'b0;

  // expected characters of one conversion
  task automatic predict_digits(input in_t it);
    logic [63:0] v;
    logic [63:0] q;
    int b, prec, len, total, room, k, pos;
    logic [5:0] dig[MAX_CHARS];
    out_t o;
    v = it.value;
    b = int'(it.base);
    prec = int'(it.precision);
    if (v == 0 && prec == 0 && (b == BASE_HEX || !it.alt_form)) begin
      o.character = 8'd0;
      o.char_valid = 1'b0;
      o.last = 1'b1;
      char_q.push_back(o);
      return;
    end
    if (b < BASE_MIN) b = BASE_MIN;
    if (b > BASE_MAX) b = BASE_MAX;
    len = 0;
    q = v;
    do begin
      q = q / b;
      len++;
    end while (q != 0);
    total = len;
    if (len <= prec) begin
      total = prec;
    end else if (len <= int'(it.width) && prec == PREC_NONE && it.zero_pad &&
                 !it.left_align) begin
      room = int'(it.width) - int'(it.sign_reserved) - int'(it.prefix_reserved)
           - int'(it.space_reserved);
      if (room > len) total = room;
    end
    if (total > MAX_CHARS) total = MAX_CHARS;
    for (k = 0; k < total; k++) dig[k] = '0;
    q = v;
    pos = total - 1;
    while (pos >= 0 && q != 0) begin
      dig[pos] = 6'(q % b);
      q = q / b;
      pos--;
    end
    for (k = 0; k < total; k++) begin
      if (dig[k] < 10) o.character = 8'h30 + dig[k];
      else o.character = (it.upper_case ? 8'h41 : 8'h61) + dig[k] - 8'd10;
      o.char_valid = 1'b1;
      o.last = (k == total - 1);
      char_q.push_back(o);
    end
  endtask

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("[unsigned_to_base_digits_padded_top] ERROR");
        $finish;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t exp_c;
    if (!rst && pop && !empty) begin
      if (char_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected beat %h", result);
      end else begin
        exp_c = char_q.pop_front();
        if (result.character !== exp_c.character || result.char_valid !== exp_c.char_valid ||
            result.last !== exp_c.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp char %h valid %b last %b, got %h %b %b",
                     exp_c.character, exp_c.char_valid, exp_c.last,
                     result.character, result.char_valid, result.last);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // send one conversion request; push stays high for a following beat
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_digits(it);
    @(negedge clk);
  endtask

  function automatic in_t rand_item();
    in_t it;
    it = '0;
    case ($urandom_range(3))
      0: it.value = {$urandom, $urandom};
      1: it.value = 64'($urandom_range(300));
      2: it.value = {$urandom, $urandom} >> $urandom_range(63);
      default: it.value = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
    endcase
    case ($urandom_range(3))
      0: it.base = 6'd16;
      1: it.base = 6'd8;
      2: it.base = 6'd10;
      default: it.base = 6'($urandom_range(63));
    endcase
    case ($urandom_range(3))
      0: it.precision = -8'sd1;
      1: it.precision = 8'($urandom_range(64));
      2: it.precision = 8'($urandom_range(3));
      default: it.precision = 8'($urandom_range(255));
    endcase
    it.width = 7'($urandom_range(127));
    it.zero_pad = 1'($urandom_range(1));
    it.left_align = ($urandom_range(3) == 0);
    it.alt_form = 1'($urandom_range(1));
    it.upper_case = 1'($urandom_range(1));
    it.sign_reserved = 1'($urandom_range(1));
    it.prefix_reserved = 2'($urandom_range(3));
    it.space_reserved = 1'($urandom_range(1));
    if ($urandom_range(7) == 0) it.value = '0;
    return it;
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    in_t it;
    it = '0;
    it.base = 6'd10; it.precision = -8'sd1;
    send_item(it);                                       // plain zero
    it.precision = 8'sd0; send_item(it);                 // empty run
    it.alt_form = 1'b1; it.base = 6'd8; send_item(it);   // octal alternate keeps zero
    it.base = 6'd16; send_item(it);                      // hex alternate stays empty
    it = '0; it.value = '1; it.base = 6'd2; it.precision = -8'sd1; send_item(it);
    it.base = 6'd36; it.upper_case = 1'b1; send_item(it);
    it.upper_case = 1'b0; send_item(it);
    it.base = 6'd0; send_item(it);                       // base clamped up
    it.base = 6'd63; send_item(it);                      // base clamped down
    it.base = 6'd1; it.value = 64'h5; send_item(it);
    it = '0; it.value = 64'hABC; it.base = 6'd16; it.precision = 8'sd64; send_item(it);
    it.precision = 8'sd10; send_item(it);
    it.precision = 8'sh80; it.width = 7'd127; it.zero_pad = 1'b1; send_item(it);
    it.precision = -8'sd1; send_item(it);                // width padding saturates
    it.width = 7'd12; it.sign_reserved = 1'b1; it.prefix_reserved = 2'd3;
    it.space_reserved = 1'b1;
    send_item(it);
    it.left_align = 1'b1; send_item(it);
    it.left_align = 1'b0; it.width = 7'd2; send_item(it); // room below digit count
    it.precision = 8'sd127; send_item(it);
    it.value = 64'hFFFF_FFFF_FFFF_FFFF; it.base = 6'd2; it.precision = 8'sd64;
    send_item(it);
    drain();
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_item(rand_item());
    drain();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(90, 0, 0);
    test_random(90, 51, 0);
    test_random(90, 0, 51);
    test_random(90, 6, 6);
    repeat (600) @(posedge clk);
    if (n_mismatch == 0 && char_q.size() == 0)
      $display("[unsigned_to_base_digits_padded_top] OK");
    else
      $display("[unsigned_to_base_digits_padded_top] ERROR");
    $finish;
  end

endmodule
